/* hw/rtl/tblrc_pkg.sv */
// ----------------------------------------------------------------------------
// tblrc_pkg: shared types and constants for the lift relay control
// Holds the field widths, the saturation limits, the configuration
// register indexes, the direction codes and the debounce event record.
// ----------------------------------------------------------------------------
package tblrc_pkg;

    // Configuration field widths.
    localparam int unsigned DEBOUNCE_W = 10;
    localparam int unsigned CLICK_W    = 12;
    localparam int unsigned TRAVEL_W   = 20;
    localparam int unsigned CFG_DATA_W = 20;
    localparam int unsigned CFG_IDX_W  = 2;

    // Age counter widths; every age saturates at all ones.
    localparam int unsigned STABLE_AGE_W = 11;
    localparam int unsigned CLICK_AGE_W  = 13;

    localparam logic [STABLE_AGE_W-1:0] STABLE_MAX = '1;
    localparam logic [CLICK_AGE_W-1:0]  CLICK_MAX  = '1;
    localparam logic [TRAVEL_W-1:0]     ELAPSED_MAX = '1;

    // Reset values of the configuration registers.
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 10'd50;
    localparam logic [CLICK_W-1:0]    CLICK_RST    = 12'd400;
    localparam logic [TRAVEL_W-1:0]   TRAVEL_RST   = 20'd30000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL   = 2'd2;

    // Reported travel direction.
    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    // Debounced edges of one button for the current tick.
    typedef struct packed {
        logic rise;
        logic fall;
    } btn_evt_t;

endpackage

/* hw/rtl/two_button_lift_relay_control.sv */
// ----------------------------------------------------------------------------
// two_button_lift_relay_control: relay control for a two-button lift
// Debounces the up and down buttons, runs manual travel while a button is
// held, timed automatic travel after a double click, and interlocks relays.
//
//   Channel   Direction  Handshake            Payload
//   s_        in         s_valid / s_ready    s_up_pressed, s_down_pressed
//   m_        out        m_valid / m_ready    m_relay_up_on, m_relay_down_on,
//                                             m_auto_active, m_direction_code
//   cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item per clock sustained while m_ready stays high; each result is offered
// on m_ once its item has passed the input register, then the result register.
// The control state updates in one pass of logic when an item moves from
// the input register into the result register.
// Reset clears all control state and loads the register defaults.
// A stalled result holds the result register; one more item waits in the
// input register, after which s_ready drops. cfg_ready is always high.
// ----------------------------------------------------------------------------
module two_button_lift_relay_control (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Tick input
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_up_pressed,
    input  logic                              s_down_pressed,
    // Result output
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_relay_up_on,
    output logic                              m_relay_down_on,
    output logic                              m_auto_active,
    output logic [1:0]                        m_direction_code,
    // Configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tblrc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tblrc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // Configuration registers.
    logic [tblrc_pkg::DEBOUNCE_W-1:0]  debounce_reg;
    logic [tblrc_pkg::CLICK_W-1:0]     click_win_reg;
    logic [tblrc_pkg::TRAVEL_W-1:0]    travel_reg;

    // Input register.
    logic in_valid_reg;
    logic in_up_reg;
    logic in_down_reg;
    logic advance;

    // Control state.
    logic                               up_relay_reg;
    logic                               down_relay_reg;
    logic                               auto_flag_reg;
    logic                               auto_is_up_reg;
    logic [tblrc_pkg::TRAVEL_W-1:0]     elapsed_reg;
    logic [tblrc_pkg::CLICK_AGE_W-1:0]  click_up_reg;
    logic [tblrc_pkg::CLICK_AGE_W-1:0]  click_down_reg;
    logic                               await_up_reg;
    logic                               await_down_reg;

    logic                               up_relay_next;
    logic                               down_relay_next;
    logic                               auto_flag_next;
    logic                               auto_is_up_next;
    logic [tblrc_pkg::TRAVEL_W-1:0]     elapsed_next;
    logic [tblrc_pkg::CLICK_AGE_W-1:0]  click_up_next;
    logic [tblrc_pkg::CLICK_AGE_W-1:0]  click_down_next;
    logic                               await_up_next;
    logic                               await_down_next;

    // Result register.
    logic       m_valid_reg;
    logic       m_up_reg;
    logic       m_down_reg;
    logic       m_auto_reg;
    logic [1:0] m_dir_reg;

    tblrc_pkg::btn_evt_t up_evt;
    tblrc_pkg::btn_evt_t down_evt;
    logic [tblrc_pkg::CLICK_AGE_W-1:0] click_win;

    // Handshakes: the input register drains whenever the result slot frees.
    assign advance   = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign click_win = {1'b0, click_win_reg};

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg  <= tblrc_pkg::DEBOUNCE_RST;
            click_win_reg <= tblrc_pkg::CLICK_RST;
            travel_reg    <= tblrc_pkg::TRAVEL_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                tblrc_pkg::CFG_DEBOUNCE: begin
                    debounce_reg <= cfg_data[tblrc_pkg::DEBOUNCE_W-1:0];
                end
                tblrc_pkg::CFG_CLICK: begin
                    click_win_reg <= cfg_data[tblrc_pkg::CLICK_W-1:0];
                end
                tblrc_pkg::CFG_TRAVEL: begin
                    travel_reg <= cfg_data[tblrc_pkg::TRAVEL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_up_reg   <= s_up_pressed;
            in_down_reg <= s_down_pressed;
        end
    end

    // Button debouncers.
    tblrc_debounce u_deb_up (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .advance        (advance),
        .raw            (in_up_reg),
        .debounce_ticks (debounce_reg),
        .evt            (up_evt)
    );

    tblrc_debounce u_deb_down (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .advance        (advance),
        .raw            (in_down_reg),
        .debounce_ticks (debounce_reg),
        .evt            (down_evt)
    );

    // Travel control for one tick: up button, then down button, then timer.
    always_comb begin
        up_relay_next   = up_relay_reg;
        down_relay_next = down_relay_reg;
        auto_flag_next  = auto_flag_reg;
        auto_is_up_next = auto_is_up_reg;
        await_up_next   = await_up_reg;
        await_down_next = await_down_reg;

        // Ages advance first and saturate.
        click_up_next = (click_up_reg != tblrc_pkg::CLICK_MAX)
                        ? click_up_reg + 1'b1 : click_up_reg;
        click_down_next = (click_down_reg != tblrc_pkg::CLICK_MAX)
                          ? click_down_reg + 1'b1 : click_down_reg;
        elapsed_next = (auto_flag_reg && elapsed_reg != tblrc_pkg::ELAPSED_MAX)
                       ? elapsed_reg + 1'b1 : elapsed_reg;

        // Up press: a second press in the window starts automatic travel.
        if (up_evt.rise) begin
            if (click_up_next < click_win && await_up_next) begin
                await_up_next = 1'b0;
                if (!down_relay_next) begin
                    up_relay_next   = 1'b1;
                    auto_flag_next  = 1'b1;
                    auto_is_up_next = 1'b1;
                    elapsed_next    = '0;
                end
            end else begin
                await_up_next = 1'b1;
                click_up_next = '0;
                if ((!auto_flag_next || auto_is_up_next) && !down_relay_next) begin
                    auto_flag_next = 1'b0;
                    up_relay_next  = 1'b1;
                end
            end
        end
        // Up release stops manual travel only.
        if (up_evt.fall) begin
            if (!auto_flag_next) begin
                up_relay_next   = 1'b0;
                down_relay_next = 1'b0;
            end
            if (await_up_next && click_up_next >= click_win) begin
                await_up_next = 1'b0;
            end
        end

        // Down press, same rules mirrored.
        if (down_evt.rise) begin
            if (click_down_next < click_win && await_down_next) begin
                await_down_next = 1'b0;
                if (!up_relay_next) begin
                    down_relay_next = 1'b1;
                    auto_flag_next  = 1'b1;
                    auto_is_up_next = 1'b0;
                    elapsed_next    = '0;
                end
            end else begin
                await_down_next = 1'b1;
                click_down_next = '0;
                if ((!auto_flag_next || !auto_is_up_next) && !up_relay_next) begin
                    auto_flag_next  = 1'b0;
                    down_relay_next = 1'b1;
                end
            end
        end
        if (down_evt.fall) begin
            if (!auto_flag_next) begin
                up_relay_next   = 1'b0;
                down_relay_next = 1'b0;
            end
            if (await_down_next && click_down_next >= click_win) begin
                await_down_next = 1'b0;
            end
        end

        // Automatic travel ends when its time is up.
        if (auto_flag_next && elapsed_next >= travel_reg) begin
            up_relay_next   = 1'b0;
            down_relay_next = 1'b0;
            auto_flag_next  = 1'b0;
        end

        // Expired double-click windows.
        if (await_up_next && click_up_next >= click_win) begin
            await_up_next = 1'b0;
        end
        if (await_down_next && click_down_next >= click_win) begin
            await_down_next = 1'b0;
        end
    end

    // Control state register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            up_relay_reg   <= 1'b0;
            down_relay_reg <= 1'b0;
            auto_flag_reg  <= 1'b0;
            auto_is_up_reg <= 1'b0;
            elapsed_reg    <= '0;
            click_up_reg   <= '0;
            click_down_reg <= '0;
            await_up_reg   <= 1'b0;
            await_down_reg <= 1'b0;
        end else if (advance) begin
            up_relay_reg   <= up_relay_next;
            down_relay_reg <= down_relay_next;
            auto_flag_reg  <= auto_flag_next;
            auto_is_up_reg <= auto_is_up_next;
            elapsed_reg    <= elapsed_next;
            click_up_reg   <= click_up_next;
            click_down_reg <= click_down_next;
            await_up_reg   <= await_up_next;
            await_down_reg <= await_down_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            m_valid_reg <= in_valid_reg;
        end
        if (advance) begin
            m_up_reg   <= up_relay_next;
            m_down_reg <= down_relay_next;
            m_auto_reg <= auto_flag_next;
            if (up_relay_next) begin
                m_dir_reg <= tblrc_pkg::DIR_UP;
            end else if (down_relay_next) begin
                m_dir_reg <= tblrc_pkg::DIR_DOWN;
            end else begin
                m_dir_reg <= tblrc_pkg::DIR_STOP;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_relay_up_on    = m_up_reg;
    assign m_relay_down_on  = m_down_reg;
    assign m_auto_active    = m_auto_reg;
    assign m_direction_code = m_dir_reg;

    // The relays interlock and never drive together.
    a_interlock: assert property (@(posedge aclk) disable iff (!aresetn)
        !(up_relay_reg && down_relay_reg))
        else $error("both relays on");

    // Automatic travel always has a relay driven.
    a_auto_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        auto_flag_reg |-> (up_relay_reg || down_relay_reg))
        else $error("automatic travel with no relay on");

    // A buffered item that cannot advance stays in the input register.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("buffered item lost");

    // The reported direction follows the up relay.
    a_dir_up: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_direction_code == tblrc_pkg::DIR_UP) == m_relay_up_on))
        else $error("direction code disagrees with up relay");

endmodule

/* hw/rtl/tblrc_debounce.sv */
// ----------------------------------------------------------------------------
// tblrc_debounce: debouncer for one lift button
// Tracks how long the raw level has been stable and reports a debounced
// press or release once it has stayed unchanged for more than the limit.
// ----------------------------------------------------------------------------
module tblrc_debounce (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              advance,
    input  logic                              raw,
    input  logic [tblrc_pkg::DEBOUNCE_W-1:0]  debounce_ticks,
    output tblrc_pkg::btn_evt_t               evt
);

    logic                                prev_reg;
    logic                                clean_reg;
    logic [tblrc_pkg::STABLE_AGE_W-1:0]  age_reg;
    logic [tblrc_pkg::STABLE_AGE_W-1:0]  age_next;
    logic                                stable;

    // Stability age restarts on a level change and saturates otherwise.
    always_comb begin
        if (raw != prev_reg) begin
            age_next = '0;
        end else if (age_reg != tblrc_pkg::STABLE_MAX) begin
            age_next = age_reg + 1'b1;
        end else begin
            age_next = age_reg;
        end
        stable   = age_next > {1'b0, debounce_ticks};
        evt.rise = stable && raw && !clean_reg;
        evt.fall = stable && !raw && clean_reg;
    end

    // State advances once per accepted tick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg  <= 1'b0;
            clean_reg <= 1'b0;
            age_reg   <= '0;
        end else if (advance) begin
            prev_reg <= raw;
            age_reg  <= age_next;
            if (stable) begin
                clean_reg <= raw;
            end
        end
    end

endmodule

/* tb/lift_relay_sb_pkg.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lift_relay_sb_pkg: relay prediction and checking for the lift relay control
// Keeps a tick-by-tick copy of the debounce, double-click, interlock and
// timed travel behavior. Each accepted tick produces one predicted relay
// state, and each relay state leaving the block is checked against the
// oldest prediction.
// ----------------------------------------------------------------------------
package lift_relay_sb_pkg;

    // Button slots in the level vector and in the per-button state.
    localparam int BTN_UP = 0;
    localparam int BTN_DN = 1;

    typedef struct packed {
        logic       up_on;
        logic       down_on;
        logic       auto_on;
        logic [1:0] dir;
    } relay_state_t;

    class lift_relay_scoreboard;
        int           fail_count;
        relay_state_t expected_relays[$];

        // Register copies.
        logic [tblrc_pkg::DEBOUNCE_W-1:0]   debounce_lim;
        logic [tblrc_pkg::CLICK_W-1:0]      click_window;
        logic [tblrc_pkg::TRAVEL_W-1:0]     travel_len;

        // Control state, one slot per button where it is per button.
        logic                               last_lvl[2];
        logic [tblrc_pkg::STABLE_AGE_W-1:0] steady_age[2];
        logic                               clean_lvl[2];
        logic [tblrc_pkg::CLICK_AGE_W-1:0]  click_age[2];
        logic                               await_second[2];
        logic                               relay_on[2];
        logic                               auto_on;
        logic                               auto_up;
        logic [tblrc_pkg::TRAVEL_W-1:0]     auto_age;

        function new();
            fail_count   = 0;
            debounce_lim = tblrc_pkg::DEBOUNCE_RST;
            click_window = tblrc_pkg::CLICK_RST;
            travel_len   = tblrc_pkg::TRAVEL_RST;
            auto_on      = 1'b0;
            auto_up      = 1'b0;
            auto_age     = '0;
            for (int b = 0; b < 2; b++) begin
                last_lvl[b]     = 1'b0;
                steady_age[b]   = '0;
                clean_lvl[b]    = 1'b0;
                click_age[b]    = '0;
                await_second[b] = 1'b0;
                relay_on[b]     = 1'b0;
            end
        endfunction

        function void set_register(logic [tblrc_pkg::CFG_IDX_W-1:0] idx,
                                   logic [tblrc_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                tblrc_pkg::CFG_DEBOUNCE: debounce_lim = data[tblrc_pkg::DEBOUNCE_W-1:0];
                tblrc_pkg::CFG_CLICK:    click_window = data[tblrc_pkg::CLICK_W-1:0];
                tblrc_pkg::CFG_TRAVEL:   travel_len   = data[tblrc_pkg::TRAVEL_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_relays.size();
        endfunction

        function void halt_all();
            relay_on[BTN_UP] = 1'b0;
            relay_on[BTN_DN] = 1'b0;
            auto_on          = 1'b0;
        endfunction

        // A move is refused while the opposite relay is on.
        function void start_manual(int b);
            if (relay_on[1-b])
                return;
            auto_on     = 1'b0;
            relay_on[b] = 1'b1;
        endfunction

        function void start_auto(int b);
            if (relay_on[1-b])
                return;
            relay_on[b] = 1'b1;
            auto_on     = 1'b1;
            auto_up     = (b == BTN_UP);
            auto_age    = '0;
        endfunction

        // Debounce one button and act on its clean edges.
        function void debounce_button(int b, logic lvl);
            logic was;
            if (lvl != last_lvl[b])
                steady_age[b] = '0;
            else if (steady_age[b] != tblrc_pkg::STABLE_MAX)
                steady_age[b]++;

            if (steady_age[b] > debounce_lim) begin
                was          = clean_lvl[b];
                clean_lvl[b] = lvl;
                if (lvl && !was) begin
                    if (click_age[b] < click_window && await_second[b]) begin
                        await_second[b] = 1'b0;
                        start_auto(b);
                    end else begin
                        await_second[b] = 1'b1;
                        click_age[b]    = '0;
                        // A press during opposite automatic travel is ignored.
                        if (!auto_on || auto_up == (b == BTN_UP))
                            start_manual(b);
                    end
                end
                if (!lvl && was) begin
                    if (!auto_on)
                        halt_all();
                    if (await_second[b] && click_age[b] >= click_window)
                        await_second[b] = 1'b0;
                end
            end
            last_lvl[b] = lvl;
        endfunction

        // Advance the control state by one accepted tick.
        function void predict_tick(logic up, logic dn);
            relay_state_t r;
            for (int b = 0; b < 2; b++) begin
                if (click_age[b] != tblrc_pkg::CLICK_MAX)
                    click_age[b]++;
            end
            if (auto_on && auto_age != tblrc_pkg::ELAPSED_MAX)
                auto_age++;

            debounce_button(BTN_UP, up);
            debounce_button(BTN_DN, dn);

            if (auto_on && auto_age >= travel_len)
                halt_all();
            for (int b = 0; b < 2; b++) begin
                if (await_second[b] && click_age[b] >= click_window)
                    await_second[b] = 1'b0;
            end

            r.up_on   = relay_on[BTN_UP];
            r.down_on = relay_on[BTN_DN];
            r.auto_on = auto_on;
            r.dir     = relay_on[BTN_UP] ? tblrc_pkg::DIR_UP
                      : (relay_on[BTN_DN] ? tblrc_pkg::DIR_DOWN : tblrc_pkg::DIR_STOP);
            expected_relays.push_back(r);
        endfunction

        function void compare_field(string name, logic [1:0] want, logic [1:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                fail_count++;
            end
        endfunction

        function void check_relays(logic up_on, logic down_on, logic auto_act, logic [1:0] dir);
            relay_state_t want;
            if (expected_relays.size() == 0) begin
                $display("%0t: unexpected relay result, expected none, actual %b %b %b %0d",
                         $time, up_on, down_on, auto_act, dir);
                fail_count++;
                return;
            end
            want = expected_relays.pop_front();
            compare_field("relay_up_on", 2'(want.up_on), 2'(up_on));
            compare_field("relay_down_on", 2'(want.down_on), 2'(down_on));
            compare_field("auto_active", 2'(want.auto_on), 2'(auto_act));
            compare_field("direction_code", want.dir, dir);
        endfunction
    endclass

endpackage

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the two-button lift relay control
// Drives button ticks through the input channel in random bursts while the
// result channel stalls on its own pattern, and checks every relay result
// against a predictor. A directed opening covers manual and automatic
// travel, interlocking, glitches and the register extremes; random phases
// with fresh register settings follow.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LATENCY      = 1;
    localparam int RANDOM_TICKS = 500;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int DEB_MAX      = (1 << tblrc_pkg::DEBOUNCE_W) - 1;
    localparam int WIN_MAX      = (1 << tblrc_pkg::CLICK_W) - 1;
    localparam int TRAVEL_MAX   = (1 << tblrc_pkg::TRAVEL_W) - 1;
    localparam int BTN_UP       = lift_relay_sb_pkg::BTN_UP;
    localparam int BTN_DN       = lift_relay_sb_pkg::BTN_DN;

    typedef enum int {RX_FREE, RX_LIGHT, RX_PERIODIC, RX_HEAVY} rx_mode_t;
    typedef enum int {G_SINGLE, G_DOUBLE, G_CROSS, G_BOUNCE, G_NOISE} gesture_t;

    logic                             aclk           = 1'b0;
    logic                             aresetn        = 1'b0;
    logic                             s_valid        = 1'b0;
    logic                             s_ready;
    logic                             s_up_pressed   = 1'b0;
    logic                             s_down_pressed = 1'b0;
    logic                             m_valid;
    logic                             m_ready        = 1'b0;
    logic                             m_relay_up_on;
    logic                             m_relay_down_on;
    logic                             m_auto_active;
    logic [1:0]                       m_direction_code;
    logic                             cfg_valid      = 1'b0;
    logic                             cfg_ready;
    logic [tblrc_pkg::CFG_IDX_W-1:0]  cfg_index      = '0;
    logic [tblrc_pkg::CFG_DATA_W-1:0] cfg_data       = '0;

    lift_relay_sb_pkg::lift_relay_scoreboard sb;
    int       cycles     = 0;
    rx_mode_t rx_mode    = RX_FREE;
    int       rx_period  = 4;
    int       burst_left = 0;
    int       ticks_sent = 0;
    logic [1:0] btn_lvl  = '0;

    two_button_lift_relay_control u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_up_pressed     (s_up_pressed),
        .s_down_pressed   (s_down_pressed),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_relay_up_on    (m_relay_up_on),
        .m_relay_down_on  (m_relay_down_on),
        .m_auto_active    (m_auto_active),
        .m_direction_code (m_direction_code),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // Clock generation.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Cycle count and run limit.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: check each accepted item, then pick the next ready level.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_relays(m_relay_up_on, m_relay_down_on, m_auto_active, m_direction_code);
        if (cycles % 256 == 0) begin
            rx_mode   <= rx_mode_t'($urandom_range(0, 3));
            rx_period <= $urandom_range(2, 12);
        end
        case (rx_mode)
            RX_FREE:     m_ready <= 1'b1;
            RX_LIGHT:    m_ready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: m_ready <= (cycles % rx_period) >= (rx_period / 2);
            default:     m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Send one tick item; the sender runs in bursts with random gaps.
    task automatic send_tick(input logic up, input logic dn);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid        <= 1'b1;
        s_up_pressed   <= up;
        s_down_pressed <= dn;
        do @(posedge aclk); while (!s_ready);
        sb.predict_tick(up, dn);
        ticks_sent++;
    endtask

    // Hold the current button levels for n ticks.
    task automatic hold(input int n);
        repeat (n) send_tick(btn_lvl[BTN_UP], btn_lvl[BTN_DN]);
    endtask

    task automatic levels(input logic up, input logic dn, input int n);
        btn_lvl[BTN_UP] = up;
        btn_lvl[BTN_DN] = dn;
        hold(n);
    endtask

    // Stop sending and wait until every predicted relay state has arrived.
    task automatic wait_idle();
        s_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() > 0) @(posedge aclk);
        repeat (LATENCY + 2) @(posedge aclk);
    endtask

    // Write all three registers back to back while the block is idle.
    task automatic set_config(input logic [tblrc_pkg::DEBOUNCE_W-1:0] deb,
                              input logic [tblrc_pkg::CLICK_W-1:0] win,
                              input logic [tblrc_pkg::TRAVEL_W-1:0] trav);
        logic [tblrc_pkg::CFG_IDX_W-1:0]  idx [3];
        logic [tblrc_pkg::CFG_DATA_W-1:0] val [3];
        wait_idle();
        idx = '{tblrc_pkg::CFG_DEBOUNCE, tblrc_pkg::CFG_CLICK, tblrc_pkg::CFG_TRAVEL};
        val = '{tblrc_pkg::CFG_DATA_W'(deb), tblrc_pkg::CFG_DATA_W'(win),
                tblrc_pkg::CFG_DATA_W'(trav)};
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge aclk); while (!cfg_ready);
            sb.set_register(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // Long enough for a level to pass the debounce filter.
    function automatic int settle(input int deb);
        return deb + 2 + $urandom_range(0, 5);
    endfunction

    // One button gesture with random timing around the current settings.
    task automatic random_gesture(input int deb, input int trav);
        int       b;
        int       other;
        int       tail;
        gesture_t kind;
        b = $urandom_range(BTN_UP, BTN_DN);
        case ($urandom_range(0, 9))
            0, 1, 2: kind = G_SINGLE;
            3, 4, 5: kind = G_DOUBLE;
            6, 7:    kind = G_CROSS;
            8:       kind = G_BOUNCE;
            default: kind = G_NOISE;
        endcase
        case (kind)
            G_SINGLE: begin
                btn_lvl[b] = 1'b1;
                hold(settle(deb));
                btn_lvl[b] = 1'b0;
                hold(settle(deb));
            end
            G_DOUBLE: begin
                btn_lvl[b] = 1'b1;
                hold(settle(deb));
                btn_lvl[b] = 1'b0;
                hold(settle(deb));
                btn_lvl[b] = 1'b1;
                hold(settle(deb));
                btn_lvl[b] = 1'b0;
                // Sometimes press a button while automatic travel runs.
                if ($urandom_range(0, 1) == 1) begin
                    other = $urandom_range(BTN_UP, BTN_DN);
                    btn_lvl[other] = 1'b1;
                    hold(settle(deb));
                    btn_lvl[other] = 1'b0;
                end
                tail = (trav > 40) ? 40 : trav;
                hold(settle(deb) + tail);
            end
            G_CROSS: begin
                btn_lvl[b] = 1'b1;
                hold(settle(deb));
                btn_lvl[1-b] = 1'b1;
                hold(settle(deb));
                btn_lvl[b] = 1'b0;
                hold(settle(deb));
                btn_lvl[1-b] = 1'b0;
                hold(settle(deb));
            end
            G_BOUNCE: begin
                repeat ($urandom_range(2, 6)) begin
                    btn_lvl[b] = ~btn_lvl[b];
                    hold($urandom_range(1, deb + 1));
                end
                btn_lvl = '0;
                hold(settle(deb));
            end
            default: begin
                repeat ($urandom_range(3, 10)) begin
                    btn_lvl = 2'($urandom);
                    hold($urandom_range(1, deb + 3));
                end
                btn_lvl = '0;
                hold(settle(deb));
            end
        endcase
    endtask

    // Main sequence.
    initial begin
        int deb;
        int win;
        int trav;
        int rnd_start;
        sb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Register defaults: a press must outlast the 50-tick debounce.
        levels(1, 0, 60);
        levels(0, 0, 60);

        // A one-tick glitch, manual travel, an interlocked request.
        set_config(0, 6, 8);
        levels(1, 0, 1);
        levels(0, 0, 3);
        levels(1, 0, 2);
        levels(1, 1, 2);
        levels(0, 1, 2);
        levels(0, 0, 8);

        // Double click down; an up press during it is ignored and the
        // release does not stop travel, the timer does.
        levels(0, 1, 2);
        levels(0, 0, 2);
        levels(0, 1, 2);
        levels(1, 1, 2);
        levels(0, 0, 8);

        // Double click up, then a third press turns it into manual travel.
        levels(1, 0, 2);
        levels(0, 0, 2);
        levels(1, 0, 2);
        levels(0, 0, 2);
        levels(1, 0, 2);
        levels(0, 0, 8);

        // A zero window never yields a double click.
        set_config(0, 0, 8);
        levels(1, 0, 2);
        levels(0, 0, 2);
        levels(1, 0, 2);
        levels(0, 0, 2);

        // With zero travel time, automatic travel ends in the tick it starts.
        set_config(0, 6, 0);
        levels(0, 1, 2);
        levels(0, 0, 2);
        levels(0, 1, 2);
        levels(0, 0, 8);

        // Largest settings: a press must outlast the longest debounce, then a
        // wide double click starts the longest timed automatic travel, and a third
        // press turns it into manual travel.
        set_config(tblrc_pkg::DEBOUNCE_W'(DEB_MAX), tblrc_pkg::CLICK_W'(WIN_MAX),
                   tblrc_pkg::TRAVEL_W'(TRAVEL_MAX));
        levels(1, 0, 1026);
        set_config(0, tblrc_pkg::CLICK_W'(WIN_MAX), tblrc_pkg::TRAVEL_W'(TRAVEL_MAX));
        levels(0, 0, 2);
        levels(1, 0, 2);
        levels(0, 0, 2);
        levels(1, 0, 2);
        levels(0, 0, 40);

        // Random phases, each with its own register settings.
        rnd_start = ticks_sent;
        while (ticks_sent - rnd_start < RANDOM_TICKS) begin
            case ($urandom_range(0, 3))
                0:       deb = 0;
                3:       deb = $urandom_range(4, 8);
                default: deb = $urandom_range(1, 3);
            endcase
            case ($urandom_range(0, 7))
                0:       win = 0;
                1:       win = WIN_MAX;
                default: win = 2 * (deb + 2) + $urandom_range(0, 14);
            endcase
            case ($urandom_range(0, 7))
                0:       trav = 1;
                1:       trav = TRAVEL_MAX;
                default: trav = $urandom_range(2, 40);
            endcase
            set_config(tblrc_pkg::DEBOUNCE_W'(deb), tblrc_pkg::CLICK_W'(win),
                       tblrc_pkg::TRAVEL_W'(trav));
            repeat ($urandom_range(6, 16)) random_gesture(deb, trav);
        end

        wait_idle();
        repeat (LATENCY + 4) @(posedge aclk);
        if (sb.fail_count == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/tblrc_pkg.sv
hw/rtl/tblrc_debounce.sv
hw/rtl/two_button_lift_relay_control.sv
tb/lift_relay_sb_pkg.sv
tb/tb_top.sv
